// ===== rtl/core/reliable_datagram_channel_defines.svh =====
// Assertion macros shared by the checker of the reliable datagram channel.
// No dependencies; include by bare file name.
`ifndef RELIABLE_DATAGRAM_CHANNEL_DEFINES_SVH
`define RELIABLE_DATAGRAM_CHANNEL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RDC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rdc_pkg.sv =====
// Package for the reliable datagram channel: command codes, register
// indexes and the result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND   = 2'd0,
    CMD_TRANSMIT = 2'd1,
    CMD_RECEIVE  = 2'd2
  } rdc_cmd_t;

  localparam logic REG_IS_CLIENT = 1'b0;
  localparam logic REG_QPORT     = 1'b1;

  localparam logic [3:0] HDR_CLIENT = 4'd10;
  localparam logic [3:0] HDR_SERVER = 4'd8;

  typedef struct packed {
    logic [31:0] tx_seq_word;
    logic [31:0] tx_ack_word;
    logic [15:0] tx_qport;
    logic        tx_has_qport;
    logic        tx_reliable;
    logic [10:0] reliable_bytes;
    logic        unreliable_sent;
    logic        rx_accepted;
    logic [30:0] rx_dropped;
    logic [31:0] drop_total;
    logic        link_fatal;
  } rdc_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/reliable_datagram_channel.sv =====
// Top level of the reliable datagram channel sequencing engine.
// Depends on rdc_pkg.
//
//  channel | signals                     | handshake
//  --------+-----------------------------+--------------------------------
//  in      | cmd, lengths, rx words      | in_valid high, in_stall low
//  out     | tx/rx result fields         | out_valid high, out_stall low
//  cfg     | cfg_index, cfg_data         | cfg_valid and cfg_ready high
//
// One transaction per cycle while in_stall is low: each item is worked in a single pass
// of logic between the input handshake and the result register.
// A skid register behind the result register takes one item while the
// result is stalled; in_stall is that skid register being full.
// Reset (rst, synchronous) returns all sequencing state to its start values
// and empties both result registers. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module reliable_datagram_channel
  import rdc_pkg::*;
#(
  parameter int PACKET_BYTES  = 1400,
  parameter int MESSAGE_BYTES = 1400
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input transactions
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [10:0] append_length,
  input  wire logic [10:0] unreliable_length,
  input  wire logic [31:0] rx_sequence_word,
  input  wire logic [31:0] rx_ack_word,
  // result transactions
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      tx_seq_word,
  output logic [31:0]      tx_ack_word,
  output logic [15:0]      tx_qport,
  output logic             tx_has_qport,
  output logic             tx_reliable,
  output logic [10:0]      reliable_bytes,
  output logic             unreliable_sent,
  output logic             rx_accepted,
  output logic [30:0]      rx_dropped,
  output logic [31:0]      drop_total,
  output logic             link_fatal,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Width of the pending and in-flight message lengths.
  localparam int LEN_W  = $clog2(MESSAGE_BYTES + 1);
  localparam int PKT_W  = $clog2(PACKET_BYTES + 1);
  localparam int MAX_W  = (LEN_W > PKT_W) ? LEN_W : PKT_W;
  // Room for sums of a length, a header or an 11-bit field, with carry.
  localparam int CALC_W = ((MAX_W > 11) ? MAX_W : 11) + 1;

  // Configuration registers
  logic        is_client;
  logic [15:0] qport_value;

  // Sequencing state
  logic [30:0]      out_seq,           out_seq_next;
  logic [30:0]      in_seq,            in_seq_next;
  logic [30:0]      in_acked,          in_acked_next;
  logic             in_rel_acked_bit,  in_rel_acked_bit_next;
  logic             rel_bit,           rel_bit_next;
  // Loaded from out_seq + 1 on a reliable send; same 31-bit width as out_seq.
  logic [30:0]      last_rel_seq,      last_rel_seq_next;
  logic             in_rel_bit,        in_rel_bit_next;
  logic [LEN_W-1:0] rel_len,           rel_len_next;
  logic [LEN_W-1:0] pending_len,       pending_len_next;
  logic             overflow_flag,     overflow_flag_next;
  logic             fatal_flag,        fatal_flag_next;
  logic [31:0]      gap_count,         gap_count_next;

  // Result register and skid register
  rdc_result_t res;
  rdc_result_t out_data;
  rdc_result_t skid_data;
  logic        skid_valid;

  logic in_take;
  logic out_take;

  // Transmit and receive scratch values
  logic              send;
  logic              load_pending;
  logic [LEN_W-1:0]  tx_len;
  logic [CALC_W-1:0] header;
  logic [CALC_W-1:0] used;
  logic [CALC_W-1:0] room;
  logic [CALC_W-1:0] append_sum;
  logic [30:0]       rx_seq;
  logic [30:0]       rx_gap;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_take   = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  // Append: grow the pending message unless it would overflow.
  assign append_sum = CALC_W'(pending_len) + CALC_W'(append_length);

  // Transmit: resend when the peer acked a later packet without flipping the
  // bit; promote the pending message when nothing is in flight.
  assign load_pending = (rel_len == '0) && (pending_len != '0);
  assign send         = ((in_acked > last_rel_seq) && (in_rel_acked_bit != rel_bit))
                        || load_pending;
  assign tx_len       = load_pending ? pending_len : rel_len;
  assign header       = is_client ? CALC_W'(HDR_CLIENT) : CALC_W'(HDR_SERVER);
  assign used         = send ? (header + CALC_W'(tx_len)) : header;
  // Room left counts as zero once the header and reliable part overrun.
  assign room         = (used > CALC_W'(PACKET_BYTES)) ? '0 : (CALC_W'(PACKET_BYTES) - used);

  // Receive: gap between the incoming sequence and the last one seen.
  assign rx_seq = rx_sequence_word[30:0];
  assign rx_gap = rx_seq - in_seq - 31'd1;

  always_comb begin
    out_seq_next          = out_seq;
    in_seq_next           = in_seq;
    in_acked_next         = in_acked;
    in_rel_acked_bit_next = in_rel_acked_bit;
    rel_bit_next          = rel_bit;
    last_rel_seq_next     = last_rel_seq;
    in_rel_bit_next       = in_rel_bit;
    rel_len_next          = rel_len;
    pending_len_next      = pending_len;
    overflow_flag_next    = overflow_flag;
    fatal_flag_next       = fatal_flag;
    gap_count_next        = gap_count;
    res                   = '0;

    unique case (cmd)
      CMD_APPEND: begin
        if (append_sum > CALC_W'(MESSAGE_BYTES)) begin
          overflow_flag_next = 1'b1;
        end else begin
          pending_len_next = LEN_W'(append_sum);
        end
      end
      CMD_TRANSMIT: begin
        if (overflow_flag) begin
          // No packet goes out; latch the fatal condition.
          fatal_flag_next = 1'b1;
        end else begin
          if (load_pending) begin
            rel_len_next     = pending_len;
            pending_len_next = '0;
            rel_bit_next     = ~rel_bit;
          end
          out_seq_next = out_seq + 31'd1;
          if (send) begin
            last_rel_seq_next = out_seq + 31'd1;
          end
          res.tx_seq_word     = {send, out_seq};
          res.tx_ack_word     = {in_rel_bit, in_seq};
          res.tx_qport        = is_client ? qport_value : 16'd0;
          res.tx_has_qport    = is_client;
          res.tx_reliable     = send;
          res.reliable_bytes  = send ? 11'(tx_len) : 11'd0;
          res.unreliable_sent = (room >= CALC_W'(unreliable_length));
        end
      end
      CMD_RECEIVE: begin
        // Drop stale and duplicate packets silently.
        if (rx_seq > in_seq) begin
          if (rx_gap != '0) begin
            gap_count_next = gap_count + 32'd1;
          end
          if (rx_ack_word[31] == rel_bit) begin
            rel_len_next = '0;
          end
          in_seq_next           = rx_seq;
          in_acked_next         = rx_ack_word[30:0];
          in_rel_acked_bit_next = rx_ack_word[31];
          if (rx_sequence_word[31]) begin
            in_rel_bit_next = ~in_rel_bit;
          end
          res.rx_accepted = 1'b1;
          res.rx_dropped  = rx_gap;
        end
      end
      default: begin
        // Unused code: no state change.
      end
    endcase

    res.drop_total = gap_count_next;
    res.link_fatal = fatal_flag_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      is_client   <= 1'b0;
      qport_value <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IS_CLIENT: is_client   <= cfg_data[0];
        REG_QPORT:     qport_value <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Sequencing state: advance on every accepted input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_seq          <= 31'd1;
      in_seq           <= '0;
      in_acked         <= '0;
      in_rel_acked_bit <= 1'b0;
      rel_bit          <= 1'b0;
      last_rel_seq     <= '0;
      in_rel_bit       <= 1'b0;
      rel_len          <= '0;
      pending_len      <= '0;
      overflow_flag    <= 1'b0;
      fatal_flag       <= 1'b0;
      gap_count        <= '0;
    end else if (in_take) begin
      out_seq          <= out_seq_next;
      in_seq           <= in_seq_next;
      in_acked         <= in_acked_next;
      in_rel_acked_bit <= in_rel_acked_bit_next;
      rel_bit          <= rel_bit_next;
      last_rel_seq     <= last_rel_seq_next;
      in_rel_bit       <= in_rel_bit_next;
      rel_len          <= rel_len_next;
      pending_len      <= pending_len_next;
      overflow_flag    <= overflow_flag_next;
      fatal_flag       <= fatal_flag_next;
      gap_count        <= gap_count_next;
    end
  end

  // Result and skid valid bits. While the skid holds a result the input is
  // stalled, so a drain of the result register only refills it from skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (in_take) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result and skid payloads
  always_ff @(posedge clk) begin
    priority if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (in_take) begin
      if (out_valid && !out_take) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign tx_seq_word     = out_data.tx_seq_word;
  assign tx_ack_word     = out_data.tx_ack_word;
  assign tx_qport        = out_data.tx_qport;
  assign tx_has_qport    = out_data.tx_has_qport;
  assign tx_reliable     = out_data.tx_reliable;
  assign reliable_bytes  = out_data.reliable_bytes;
  assign unreliable_sent = out_data.unreliable_sent;
  assign rx_accepted     = out_data.rx_accepted;
  assign rx_dropped      = out_data.rx_dropped;
  assign drop_total      = out_data.drop_total;
  assign link_fatal      = out_data.link_fatal;

endmodule

`default_nettype wire

// ===== rtl/core/rdc_checker.sv =====
// Port-level checker for the reliable datagram channel, with its bind.
// Depends on reliable_datagram_channel_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "reliable_datagram_channel_defines.svh"

module rdc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] tx_seq_word,
  input wire logic [31:0] tx_ack_word,
  input wire logic [15:0] tx_qport,
  input wire logic        tx_has_qport,
  input wire logic        tx_reliable,
  input wire logic [10:0] reliable_bytes,
  input wire logic        unreliable_sent,
  input wire logic        rx_accepted,
  input wire logic [30:0] rx_dropped,
  input wire logic [31:0] drop_total,
  input wire logic        link_fatal
);

  logic [158:0] out_word;
  logic         out_hold;
  logic         tx_clear;
  logic         flags_ok;

  assign out_word = {tx_seq_word, tx_ack_word, tx_qport, tx_has_qport, tx_reliable,
                     reliable_bytes, unreliable_sent, rx_accepted, rx_dropped,
                     drop_total, link_fatal};
  assign out_hold = out_valid && out_stall;
  assign tx_clear = !tx_reliable && !tx_has_qport && !unreliable_sent &&
                    (tx_seq_word == 32'd0) && (tx_ack_word == 32'd0);
  assign flags_ok = (tx_reliable || reliable_bytes == 11'd0) &&
                    (tx_has_qport || tx_qport == 16'd0) &&
                    (tx_reliable == tx_seq_word[31]);

  // Hold a stalled result.
  `RDC_ASSERT_NEXT(a_out_hold, clk, rst, out_hold, out_valid && $stable(out_word), "stalled result changed")

  // A receive result never carries transmit fields.
  `RDC_ASSERT_NOW(a_rx_tx_excl, clk, rst, out_valid && rx_accepted, tx_clear, "rx result has tx fields")

  // Reliable length and qport only accompany their flags.
  `RDC_ASSERT_NOW(a_tx_flags, clk, rst, out_valid, flags_ok, "transmit flags disagree with fields")

  // A gap count only accompanies an accepted packet.
  `RDC_ASSERT_NOW(a_rx_gap, clk, rst, out_valid && !rx_accepted, rx_dropped == 31'd0, "stray gap count")

endmodule

bind reliable_datagram_channel rdc_checker u_rdc_checker (.*);

`default_nettype wire
